// File: hw/rtl/mlqs_pkg.sv
// ----------------------------------------------------------------------------
// mlqs_pkg
// Shared types and constants of the multilevel slot scheduler: sizes,
// operation and status codes, request and response structs, and the
// command group between controller and datapath.
// ----------------------------------------------------------------------------
package mlqs_pkg;

    localparam int NUM_PRIO    = 16;
    localparam int QUEUE_DEPTH = 16;

    localparam int LVL_W  = $clog2(NUM_PRIO);
    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_W = $clog2(NUM_PRIO + 1);
    localparam int ADDR_W = $clog2(NUM_PRIO * QUEUE_DEPTH);

    localparam logic KIND_ADD = 1'b0;
    localparam logic KIND_GET = 1'b1;

    localparam logic [1:0] ST_ADDED   = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_GRANTED = 2'd2;
    localparam logic [1:0] ST_NONE    = 2'd3;

    typedef struct packed {
        logic       kind;
        logic [7:0] proc_id;
        logic [3:0] prio;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] granted_id;
        logic [3:0] granted_prio;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

endpackage

// File: hw/rtl/mlq_slot_scheduler.sv
// ----------------------------------------------------------------------------
// mlq_slot_scheduler
// Multilevel ready queue with one FIFO per priority level and a slot quota
// per level; hands out the next process on request.
// ----------------------------------------------------------------------------
// Usage: raise start with a request on i_req while busy is low; the request
// is taken at that clock edge. An add request queues proc_id at level prio,
// or is dropped if that FIFO is full. A get request serves the lowest level
// that has both entries and quota left; with none such, all quotas are
// refilled and the lowest non-empty level is served.
// Exactly one response appears on o_rsp once the request has passed the
// update cycle, marked by o_valid for a single cycle. The receiver cannot
// stall: the response must be captured in that cycle.
// The level is picked as the request is taken; the update cycle then reads
// or writes the shared entry memory and updates pointers.
// busy is high only in the update cycle, so a new request can be taken in
// the cycle in which the previous response is shown.
// Synchronous reset empties every FIFO and sets each quota to the number
// of levels minus the level; entry memory needs no clearing pass.
// ----------------------------------------------------------------------------
module mlq_slot_scheduler (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  mlqs_pkg::t_req i_req,
    output logic           busy,
    output logic           o_valid,
    output mlqs_pkg::t_rsp o_rsp
);

    mlqs_pkg::t_cmd cmd;

    mlqs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    mlqs_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

// File: hw/rtl/mlqs_ctrl.sv
// ----------------------------------------------------------------------------
// mlqs_ctrl
// Sequencer of the scheduler: takes a request, runs the update cycle in the
// datapath and presents the response for one cycle.
// ----------------------------------------------------------------------------
module mlqs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output logic          o_valid,
    output mlqs_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       load;

    assign busy       = (r_state == S_EXEC);
    assign load       = start && !busy;
    assign o_valid    = (r_state == S_OUT);
    assign o_cmd.load = load;
    assign o_cmd.exec = (r_state == S_EXEC);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (load) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                // A new request may be taken while the response is shown.
                n_state = load ? S_EXEC : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hw/rtl/mlqs_datapath.sv
// ----------------------------------------------------------------------------
// mlqs_datapath
// Per-level FIFO pointers, counts and slot quotas, the shared entry memory,
// the level pick and the response register.
// ----------------------------------------------------------------------------
module mlqs_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mlqs_pkg::t_cmd i_cmd,
    input  mlqs_pkg::t_req i_req,
    output mlqs_pkg::t_rsp o_rsp
);

    localparam int NP = mlqs_pkg::NUM_PRIO;
    localparam int LW = mlqs_pkg::LVL_W;
    localparam int IW = mlqs_pkg::IDX_W;
    localparam int CW = mlqs_pkg::CNT_W;
    localparam int SW = mlqs_pkg::SLOT_W;
    localparam int AW = mlqs_pkg::ADDR_W;

    function automatic logic [LW-1:0] first_set(input logic [NP-1:0] v);
        logic [LW-1:0] idx;
        idx = '0;
        for (int p = NP - 1; p >= 0; p--) begin
            if (v[p]) idx = LW'(p);
        end
        return idx;
    endfunction

    function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] idx);
        logic [IW-1:0] nxt;
        nxt = (idx == IW'(mlqs_pkg::QUEUE_DEPTH - 1)) ? '0 : idx + IW'(1);
        return nxt;
    endfunction

    // Captured request and pick.
    logic          r_kind;
    logic [7:0]    r_pid;
    logic          r_bad;
    logic [LW-1:0] r_lvl;
    logic          r_found;
    logic          r_refill;

    // Per-level control state.
    logic [IW-1:0] r_head  [NP];
    logic [IW-1:0] r_tail  [NP];
    logic [CW-1:0] r_count [NP];
    logic [SW-1:0] r_slots [NP];
    logic [NP-1:0] r_nonempty;
    logic [NP-1:0] r_has_slot;

    logic [7:0]    mem [NP * mlqs_pkg::QUEUE_DEPTH];
    logic [7:0]    r_rd_data;
    logic [1:0]    r_status;
    logic [3:0]    r_gprio;

    logic [NP-1:0] eligible;
    logic          any_elig;
    logic [CW-1:0] cur_cnt;
    logic          full;
    logic          add_ok;
    logic          take;
    logic [SW-1:0] base_slot;
    logic [SW-1:0] new_slot;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    assign eligible = r_nonempty & r_has_slot;
    assign any_elig = |eligible;

    // Level selection happens as the request is taken.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_req.kind;
            r_pid  <= i_req.proc_id;
            if (i_req.kind == mlqs_pkg::KIND_ADD) begin
                r_bad    <= (32'(i_req.prio) >= 32'(NP));
                r_lvl    <= (32'(i_req.prio) >= 32'(NP)) ? '0 : LW'(i_req.prio);
                r_found  <= 1'b0;
                r_refill <= 1'b0;
            end else begin
                r_bad    <= 1'b0;
                r_lvl    <= any_elig ? first_set(eligible) : first_set(r_nonempty);
                r_found  <= |r_nonempty;
                r_refill <= !any_elig;
            end
        end
    end

    assign cur_cnt = r_count[r_lvl];
    assign full    = (cur_cnt == CW'(mlqs_pkg::QUEUE_DEPTH));
    assign add_ok  = (r_kind == mlqs_pkg::KIND_ADD) && !r_bad && !full;
    assign take    = (r_kind == mlqs_pkg::KIND_GET) && r_found;

    assign base_slot = r_refill ? (SW'(NP) - SW'(r_lvl)) : r_slots[r_lvl];
    assign new_slot  = (base_slot != '0) ? base_slot - SW'(1) : base_slot;

    assign wr_addr = AW'(r_lvl) * AW'(mlqs_pkg::QUEUE_DEPTH) + AW'(r_tail[r_lvl]);
    assign rd_addr = AW'(r_lvl) * AW'(mlqs_pkg::QUEUE_DEPTH) + AW'(r_head[r_lvl]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NP; p++) begin
                r_head[p]  <= '0;
                r_tail[p]  <= '0;
                r_count[p] <= '0;
                r_slots[p] <= SW'(NP - p);
            end
            r_nonempty <= '0;
            r_has_slot <= '1;
        end else if (i_cmd.exec) begin
            // A refill covers every level; the served level is then charged.
            for (int p = 0; p < NP; p++) begin
                if (take && (r_lvl == LW'(p))) begin
                    r_slots[p]    <= new_slot;
                    r_has_slot[p] <= (new_slot != '0);
                end else if (r_refill) begin
                    r_slots[p]    <= SW'(NP - p);
                    r_has_slot[p] <= 1'b1;
                end
            end
            if (take) begin
                r_head[r_lvl]     <= next_idx(r_head[r_lvl]);
                r_count[r_lvl]    <= cur_cnt - CW'(1);
                r_nonempty[r_lvl] <= (cur_cnt != CW'(1));
            end
            if (add_ok) begin
                r_tail[r_lvl]     <= next_idx(r_tail[r_lvl]);
                r_count[r_lvl]    <= cur_cnt + CW'(1);
                r_nonempty[r_lvl] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && add_ok) begin
            mem[wr_addr] <= r_pid;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (r_kind == mlqs_pkg::KIND_ADD) begin
                r_status <= add_ok ? mlqs_pkg::ST_ADDED : mlqs_pkg::ST_DROPPED;
            end else begin
                r_status <= r_found ? mlqs_pkg::ST_GRANTED : mlqs_pkg::ST_NONE;
            end
            r_gprio <= take ? 4'(r_lvl) : 4'd0;
        end
    end

    assign o_rsp.status       = r_status;
    assign o_rsp.granted_id   = (r_status == mlqs_pkg::ST_GRANTED) ? r_rd_data : 8'd0;
    assign o_rsp.granted_prio = r_gprio;

endmodule

// File: hw/rtl/mlqs_checker.sv
// ----------------------------------------------------------------------------
// mlqs_props
// Port-level checks of the scheduler's request timing and response fields.
// ----------------------------------------------------------------------------
module mlqs_props (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input mlqs_pkg::t_req i_req,
    input logic           busy,
    input logic           o_valid,
    input mlqs_pkg::t_rsp o_rsp
);

    logic accept;
    assign accept = start && !busy;

    // Every request taken is answered by o_valid once its update cycle is over.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##2 o_valid)
        else $error("response missing two cycles after request");

    // A request is always followed by the busy update cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy && !o_valid)
        else $error("busy not raised after request");

    // Only a grant carries an id and a level.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_rsp.status != mlqs_pkg::ST_GRANTED) |->
            (o_rsp.granted_id == 8'd0) && (o_rsp.granted_prio == 4'd0))
        else $error("non-grant response carries payload");

    // An add request is answered as added or dropped, never as a get.
    a_add_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_req.kind == mlqs_pkg::KIND_ADD) |-> ##2
            (o_rsp.status == mlqs_pkg::ST_ADDED || o_rsp.status == mlqs_pkg::ST_DROPPED))
        else $error("add request answered with get status");

    // A get request is answered as granted or nothing waiting.
    a_get_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_req.kind == mlqs_pkg::KIND_GET) |-> ##2
            (o_rsp.status == mlqs_pkg::ST_GRANTED || o_rsp.status == mlqs_pkg::ST_NONE))
        else $error("get request answered with add status");

endmodule

bind mlq_slot_scheduler mlqs_props u_mlqs_props (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .i_req   (i_req),
    .busy    (busy),
    .o_valid (o_valid),
    .o_rsp   (o_rsp)
);

// File: tb/mlqs_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mlqs_checker
// Watches the request and response channels of the multilevel slot
// scheduler, keeps its own copy of the per-level FIFOs and quotas, predicts
// the response to every accepted request and compares each response, field
// by field, with the oldest one still awaited.
// ----------------------------------------------------------------------------
module mlqs_checker
    import mlqs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  logic busy,
    input  t_req i_req,
    input  logic o_valid,
    input  t_rsp o_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int MAX_REPORTS = 10;

    logic [7:0]        slot_mem [NUM_PRIO][QUEUE_DEPTH];
    logic [IDX_W-1:0]  rd_ptr   [NUM_PRIO];
    logic [IDX_W-1:0]  wr_ptr   [NUM_PRIO];
    logic [CNT_W-1:0]  fill     [NUM_PRIO];
    logic [SLOT_W-1:0] quota    [NUM_PRIO];

    t_rsp awaited_rsp [$];
    int   fail_count = 0;

    function automatic void refill_quotas();
        for (int p = 0; p < NUM_PRIO; p++) begin
            quota[p] = SLOT_W'(NUM_PRIO - p);
        end
    endfunction

    // First level holding entries (and, if asked, quota left); NUM_PRIO if none.
    function automatic int pick_level(input bit need_quota);
        for (int p = 0; p < NUM_PRIO; p++) begin
            if (fill[p] != 0 && (!need_quota || quota[p] != 0)) begin
                return p;
            end
        end
        return NUM_PRIO;
    endfunction

    function automatic t_rsp schedule(input t_req req);
        int   lvl;
        t_rsp rsp;
        rsp = '0;
        if (req.kind == KIND_ADD) begin
            lvl = int'(req.prio);
            if (lvl >= NUM_PRIO || fill[lvl] >= QUEUE_DEPTH) begin
                rsp.status = ST_DROPPED;
            end else begin
                slot_mem[lvl][wr_ptr[lvl]] = req.proc_id;
                wr_ptr[lvl] = IDX_W'((int'(wr_ptr[lvl]) + 1) % QUEUE_DEPTH);
                fill[lvl]   = fill[lvl] + 1'b1;
                rsp.status  = ST_ADDED;
            end
            return rsp;
        end
        lvl = pick_level(1'b1);
        if (lvl >= NUM_PRIO) begin
            // No level has both entries and quota: every quota is refilled,
            // even when there is nothing at all to hand out.
            refill_quotas();
            lvl = pick_level(1'b0);
            if (lvl >= NUM_PRIO) begin
                rsp.status = ST_NONE;
                return rsp;
            end
        end
        rsp.status       = ST_GRANTED;
        rsp.granted_id   = slot_mem[lvl][rd_ptr[lvl]];
        rsp.granted_prio = 4'(lvl);
        rd_ptr[lvl] = IDX_W'((int'(rd_ptr[lvl]) + 1) % QUEUE_DEPTH);
        fill[lvl]   = fill[lvl] - 1'b1;
        if (quota[lvl] != 0) begin
            quota[lvl] = quota[lvl] - 1'b1;
        end
        return rsp;
    endfunction

    always @(posedge i_clk) begin : watch
        t_rsp want;
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PRIO; p++) begin
                rd_ptr[p] = '0;
                wr_ptr[p] = '0;
                fill[p]   = '0;
            end
            refill_quotas();
            awaited_rsp.delete();
        end else begin
            if (o_valid === 1'b1) begin
                if (awaited_rsp.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t: response with no request awaiting it: status %0d id %0d prio %0d",
                                 $realtime, o_rsp.status, o_rsp.granted_id, o_rsp.granted_prio);
                    end
                end else begin
                    want = awaited_rsp.pop_front();
                    if (o_rsp.status !== want.status || o_rsp.granted_id !== want.granted_id
                            || o_rsp.granted_prio !== want.granted_prio) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("%0t: mismatch: expected status %0d id %0d prio %0d, got status %0d id %0d prio %0d",
                                     $realtime, want.status, want.granted_id, want.granted_prio,
                                     o_rsp.status, o_rsp.granted_id, o_rsp.granted_prio);
                        end
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                awaited_rsp.push_back(schedule(i_req));
            end
        end
        o_pending    <= awaited_rsp.size();
        o_fail_count <= fail_count;
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the multilevel slot scheduler with a directed set of requests and
// then with random blocks of adds and gets, with random gaps between them,
// and reports the verdict of the checker that runs beside the block.
// ----------------------------------------------------------------------------
module tb_top;
    import mlqs_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_BLOCKS = 20;
    localparam int BLOCK_LEN     = 50;
    localparam int TAIL_CYCLES   = 8;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    t_req        i_req   = '0;
    logic        busy;
    logic        o_valid;
    t_rsp        o_rsp;
    int          fail_count;
    int          pending_count;
    int unsigned cycle_count = 0;
    bit          burst = 1'b0;

    mlq_slot_scheduler dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_req  (i_req),
        .busy   (busy),
        .o_valid(o_valid),
        .o_rsp  (o_rsp)
    );

    mlqs_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .o_rsp       (o_rsp),
        .o_fail_count(fail_count),
        .o_pending   (pending_count)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Holds the request until it is taken, then idles for a random gap.
    // With no gap, start stays high for the next request.
    task automatic issue(input logic kind, input logic [7:0] id, input logic [3:0] prio);
        t_req req;
        int   gap;
        req.kind    = kind;
        req.proc_id = id;
        req.prio    = prio;
        gap = burst ? 0 : $urandom_range(0, 15);
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        int get_pct;
        bit narrow;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: a get with nothing waiting, the extremes of id and
        // level, draining back to empty, then one level filled past full.
        issue(KIND_GET, 8'hFF, 4'hF);
        issue(KIND_ADD, 8'h00, 4'h0);
        issue(KIND_ADD, 8'hFF, 4'hF);
        issue(KIND_ADD, 8'h5A, 4'hA);
        issue(KIND_GET, 8'h00, 4'h0);
        issue(KIND_GET, 8'hA5, 4'h5);
        issue(KIND_GET, 8'hFF, 4'hF);
        issue(KIND_GET, 8'h3C, 4'h3);
        for (int i = 0; i < QUEUE_DEPTH + 1; i++) begin
            issue(KIND_ADD, 8'(8'hC0 + i), 4'h9);
        end
        issue(KIND_GET, 8'h00, 4'h0);

        // Random part: each block has its own mix of adds and gets, so the
        // FIFOs fill up and drain and the quotas run out, and sometimes
        // the adds crowd onto a few high-priority levels.
        for (int b = 0; b < RANDOM_BLOCKS; b++) begin
            get_pct = $urandom_range(10, 90);
            narrow  = $urandom_range(0, 1);
            burst   = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < BLOCK_LEN; i++) begin
                issue(($urandom_range(1, 100) <= get_pct) ? KIND_GET : KIND_ADD,
                      8'($urandom_range(0, 255)),
                      narrow ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15)));
            end
        end
        start <= 1'b0;

        // Let the registered count of awaited responses catch up with the last request.
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
